/* rtl/tld_pkg.sv */
// Shared types, codes and sizes for the task lease dispatcher.
package tld_pkg;

  localparam int TABLE_DEPTH    = 128;
  localparam int CLIENT_ID_BITS = 16;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int OWNER_W = (CLIENT_ID_BITS < 16) ? CLIENT_ID_BITS : 16;
  localparam int TIME_W  = 32;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TASKS_IN_USE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TIMEOUT = CFG_IDX_W'(1);

  localparam logic [15:0] LEASE_TIMEOUT_RESET = 16'd30;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RESULT  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_NEW_LEASE = 3'd0,
    STAT_RESENT    = 3'd1,
    STAT_NONE_FREE = 3'd2,
    STAT_COMPLETED = 3'd3,
    STAT_IGNORED   = 3'd4,
    STAT_RELEASED  = 3'd5,
    STAT_NOTHING   = 3'd6,
    STAT_TICK      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]  tasks_in_use;
    logic [15:0] lease_timeout;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  entry_idx;
    logic [7:0]  freed_count;
    logic        all_done;
  } res_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [TIME_W-1:0]  start;
  } entry_t;

endpackage

/* rtl/tld_if.sv */
// Handshake channels: command items, result items and config writes.
interface tld_req_if import tld_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] client_id;

  modport source (output valid, output opcode, output client_id, input ready);
  modport sink   (input valid, input opcode, input client_id, output ready);
endinterface

interface tld_rsp_if import tld_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] entry_idx;
  logic [7:0] freed_count;
  logic       all_done;

  modport source (output valid, output status, output entry_idx, output freed_count,
                  output all_done, input ready);
  modport sink   (input valid, input status, input entry_idx, input freed_count,
                  input all_done, output ready);
endinterface

interface tld_cfg_if import tld_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tld_ram.sv */
// Simple dual-port RAM, one write and one registered read port.
module tld_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tld_core.sv */
// Lease table engine: flag vectors, entry RAM and the per-item scan sequencer.
module tld_core import tld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  op_t         in_op,
  input  logic [15:0] in_client_id,
  input  cfg_t        cfg,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  state_t state, state_next;

  op_t                op;
  logic [OWNER_W-1:0] who;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   n_val;
  logic               eval_valid;
  logic [IDX_W-1:0]   eval_idx;
  logic [TABLE_DEPTH-1:0] held_bits;
  logic [TABLE_DEPTH-1:0] done_bits;
  logic [TIME_W-1:0]  time_now;
  logic               done_flag;
  logic               found_held;
  logic [IDX_W-1:0]   held_k;
  logic               found_free;
  logic [IDX_W-1:0]   free_k;
  logic [CNT_W-1:0]   undone_cnt;
  logic [CNT_W-1:0]   freed;

  logic               take;
  logic               commit;
  logic               issue;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_entry;
  logic [$bits(entry_t)-1:0] rd_data;
  entry_t             ent;

  logic               e_held;
  logic               e_done;
  logic               e_live;
  logic               e_match;
  logic [TIME_W-1:0]  e_age;
  logic               e_expired;

  tld_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign n_val = (32'(cfg.tasks_in_use) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(cfg.tasks_in_use);

  // Entry under evaluation, read out in the cycle after its read address was issued.
  assign ent       = entry_t'(rd_data);
  assign e_held    = held_bits[eval_idx];
  assign e_done    = done_bits[eval_idx];
  assign e_live    = e_held && !e_done;
  assign e_match   = e_live && (ent.owner == who);
  assign e_age     = time_now - ent.start;
  assign e_expired = e_live && (e_age > {16'b0, cfg.lease_timeout});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = (state == S_IDLE);
    res_valid  = (state == S_FINISH);
    issue      = (state == S_SCAN) && (cnt < n);
    take       = in_valid && in_ready;
    commit     = res_valid && res_ready;

    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !eval_valid) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    res.status      = STAT_TICK;
    res.entry_idx   = '0;
    res.freed_count = '0;
    res.all_done    = done_flag;
    unique case (op)
      OP_REQUEST: begin
        if (found_held) begin
          res.status    = STAT_RESENT;
          res.entry_idx = 7'(held_k);
        end else if (found_free) begin
          res.status    = STAT_NEW_LEASE;
          res.entry_idx = 7'(free_k);
        end else begin
          res.status = STAT_NONE_FREE;
        end
      end
      OP_RESULT: begin
        if (found_held) begin
          res.status    = STAT_COMPLETED;
          res.entry_idx = 7'(held_k);
          // held entry is the last one still open
          if (undone_cnt == CNT_W'(1)) res.all_done = 1'b1;
        end else begin
          res.status = STAT_IGNORED;
        end
      end
      OP_RELEASE: begin
        res.status      = (freed != '0) ? STAT_RELEASED : STAT_NOTHING;
        res.freed_count = 8'(freed);
      end
      OP_TICK: begin
        res.status      = STAT_TICK;
        res.freed_count = 8'(freed);
      end
      default: res.status = STAT_TICK;
    endcase

    wr_en          = commit && (op == OP_REQUEST) && !found_held && found_free;
    wr_addr        = free_k;
    wr_entry.owner = who;
    wr_entry.start = time_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= OP_REQUEST;
      held_bits  <= '0;
      done_bits  <= '0;
      time_now   <= '0;
      done_flag  <= 1'b0;
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= issue;
      eval_idx   <= cnt[IDX_W-1:0];
      if (issue) cnt <= cnt + CNT_W'(1);

      if (take) begin
        op         <= in_op;
        who        <= in_client_id[OWNER_W-1:0];
        cnt        <= '0;
        n          <= n_val;
        found_held <= 1'b0;
        found_free <= 1'b0;
        undone_cnt <= '0;
        freed      <= '0;
        if (in_op == OP_TICK) time_now <= time_now + TIME_W'(1);
      end

      if (eval_valid) begin
        unique case (op)
          OP_REQUEST, OP_RESULT: begin
            if (e_match && !found_held) begin
              found_held <= 1'b1;
              held_k     <= eval_idx;
            end
            if (!e_held && !e_done && !found_free) begin
              found_free <= 1'b1;
              free_k     <= eval_idx;
            end
            if (!e_done) undone_cnt <= undone_cnt + CNT_W'(1);
          end
          OP_RELEASE: begin
            if (e_match) begin
              held_bits[eval_idx] <= 1'b0;
              freed               <= freed + CNT_W'(1);
            end
          end
          OP_TICK: begin
            if (e_expired) begin
              held_bits[eval_idx] <= 1'b0;
              freed               <= freed + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end

      if (commit) begin
        if (wr_en) held_bits[free_k] <= 1'b1;
        if (op == OP_RESULT && found_held) begin
          done_bits[held_k] <= 1'b1;
          done_flag         <= res.all_done;
        end
      end
    end
  end

endmodule

/* rtl/task_lease_dispatcher.sv */
// Task lease dispatcher: with n = min(tasks_in_use, 128), each accepted item is scanned
// as n entry RAM reads through the single read port; the last read is then evaluated,
// the scan is closed, and a finish state hands the result to the output register.
// The core takes no new item before its last result is committed; a finished result
// waits in the output register while the next item is scanned.
// Reset (synchronous): lease and done flags, time and all-done clear at once; entry RAM
// is not cleared, an entry's contents only count while its lease flag is set.
module task_lease_dispatcher import tld_pkg::*; (
  input logic      clk,
  input logic      rst,
  tld_req_if.sink  req,
  tld_rsp_if.source rsp,
  tld_cfg_if.sink  cfg
);

  cfg_t cfg_regs;
  logic core_res_valid;
  logic core_res_ready;
  res_t core_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.tasks_in_use  <= '0;
      cfg_regs.lease_timeout <= LEASE_TIMEOUT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_TASKS_IN_USE:  cfg_regs.tasks_in_use  <= cfg.data[7:0];
        CFG_LEASE_TIMEOUT: cfg_regs.lease_timeout <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  tld_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .in_op        (op_t'(req.opcode)),
    .in_client_id (req.client_id),
    .cfg          (cfg_regs),
    .res_valid    (core_res_valid),
    .res_ready    (core_res_ready),
    .res          (core_res)
  );

  // output register
  assign core_res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (core_res_ready) begin
      rsp.valid <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_ready && core_res_valid) begin
      rsp.status      <= core_res.status;
      rsp.entry_idx   <= core_res.entry_idx;
      rsp.freed_count <= core_res.freed_count;
      rsp.all_done    <= core_res.all_done;
    end
  end

`ifndef NO_ASSERTIONS
  // a taken item keeps the core busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("core accepted back-to-back items");

  a_index_only_with_entry: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !(rsp.status == STAT_NEW_LEASE || rsp.status == STAT_RESENT ||
                   rsp.status == STAT_COMPLETED) |-> rsp.entry_idx == '0)
    else $error("entry index set on a status without an entry");

  a_freed_only_release_tick: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !(rsp.status == STAT_RELEASED || rsp.status == STAT_TICK)
    |-> rsp.freed_count == '0)
    else $error("freed count set on a status that frees nothing");

  a_released_frees: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == STAT_RELEASED |-> rsp.freed_count != '0)
    else $error("release reported with nothing freed");
`endif

endmodule
